// ===== rtl/cellular_nearest_distance_unit_defines.svh =====
// Assertion helpers used by the datapath RTL (cnd_dp). They compile away for synthesis.
`ifndef CELLULAR_NEAREST_DISTANCE_UNIT_DEFINES_SVH
`define CELLULAR_NEAREST_DISTANCE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CND_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CND_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CND_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CND_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/cnd_pkg.sv =====
package cnd_pkg;

  // Sizing
  localparam int MAX_POINTS      = 64;
  localparam int MAX_SIDE_PIXELS = 2048;

  localparam int COORD_W     = 11;
  localparam int SLOT_W      = 6;
  localparam int DIST_W      = 23;
  localparam int SIDE_W      = $clog2(MAX_SIDE_PIXELS + 1);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_W        = 2 * COORD_W;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int AREA_W      = 2 * SIDE_W;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int GRID_W      = 12;
  localparam int COUNT_W     = 7;

  localparam logic [GRID_W-1:0]  GRID_WIDTH_RESET  = GRID_W'(512);
  localparam logic [GRID_W-1:0]  GRID_HEIGHT_RESET = GRID_W'(512);
  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_WIDTH     = 2'd0,
    CFG_GRID_HEIGHT    = 2'd1,
    CFG_POINT_COUNT    = 2'd2,
    CFG_SECOND_NEAREST = 2'd3
  } cnd_cfg_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } cnd_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } cnd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic write_pt;
    logic issue;
    logic load_out;
  } cnd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic issue_last;
    logic pipe_empty;
    logic out_free;
  } cnd_stat_t;

endpackage

// ===== rtl/cnd_ram.sv =====
module cnd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cnd_ctrl.sv =====
module cnd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  cnd_pkg::cnd_stat_t stat_i,
  output cnd_pkg::cnd_cmd_t  cmd_o
);

  cnd_pkg::cnd_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cnd_pkg::ST_IDLE: begin
        if (in_valid_i && (mode_i == cnd_pkg::MODE_QUERY)) begin
          state_d = stat_i.cnt_zero ? cnd_pkg::ST_DRAIN : cnd_pkg::ST_SCAN;
        end
      end
      cnd_pkg::ST_SCAN: begin
        if (stat_i.issue_last) begin
          state_d = cnd_pkg::ST_DRAIN;
        end
      end
      cnd_pkg::ST_DRAIN: begin
        if (stat_i.pipe_empty) begin
          state_d = cnd_pkg::ST_OUT;
        end
      end
      cnd_pkg::ST_OUT: begin
        if (stat_i.out_free) begin
          state_d = cnd_pkg::ST_IDLE;
        end
      end
      default: state_d = cnd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      cnd_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.start    = in_valid_i && (mode_i == cnd_pkg::MODE_QUERY);
        cmd_o.write_pt = in_valid_i && (mode_i == cnd_pkg::MODE_LOAD);
      end
      cnd_pkg::ST_SCAN: begin
        cmd_o.issue = 1'b1;
      end
      cnd_pkg::ST_DRAIN: begin
      end
      cnd_pkg::ST_OUT: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/cnd_dp.sv =====
`include "cellular_nearest_distance_unit_defines.svh"

module cnd_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cnd_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [cnd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [cnd_pkg::SLOT_W-1:0]          point_slot_i,
  input  logic [cnd_pkg::COORD_W-1:0]         coord_x_i,
  input  logic [cnd_pkg::COORD_W-1:0]         coord_y_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [cnd_pkg::DIST_W-1:0]          distance_sq_o,
  input  cnd_pkg::cnd_cmd_t                   cmd_i,
  output cnd_pkg::cnd_stat_t                  stat_o
);

  // Clamp a grid side into 1 .. MAX_SIDE_PIXELS
  function automatic logic [cnd_pkg::SIDE_W-1:0] side_of(
    input logic [cnd_pkg::GRID_W-1:0] v
  );
    logic [cnd_pkg::SIDE_W-1:0] r;
    if (v == '0) begin
      r = cnd_pkg::SIDE_W'(1);
    end else if (int'(v) > cnd_pkg::MAX_SIDE_PIXELS) begin
      r = cnd_pkg::SIDE_W'(cnd_pkg::MAX_SIDE_PIXELS);
    end else begin
      r = cnd_pkg::SIDE_W'(v);
    end
    return r;
  endfunction

  // Absolute difference folded across the torus; magnitude of the fold
  function automatic logic [cnd_pkg::COORD_W-1:0] wrap_diff(
    input logic [cnd_pkg::COORD_W-1:0] a,
    input logic [cnd_pkg::COORD_W-1:0] b,
    input logic [cnd_pkg::SIDE_W-1:0]  side
  );
    logic [cnd_pkg::COORD_W-1:0] d;
    logic [cnd_pkg::SIDE_W-1:0]  dext;
    logic [cnd_pkg::SIDE_W-1:0]  half;
    logic [cnd_pkg::COORD_W-1:0] r;
    d    = (a >= b) ? (a - b) : (b - a);
    dext = cnd_pkg::SIDE_W'(d);
    half = side >> 1;
    if (dext > half) begin
      if (side >= dext) begin
        r = cnd_pkg::COORD_W'(side - dext);
      end else begin
        r = cnd_pkg::COORD_W'(dext - side);
      end
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Configuration registers
  logic [cnd_pkg::GRID_W-1:0]  grid_width_q;
  logic [cnd_pkg::GRID_W-1:0]  grid_height_q;
  logic [cnd_pkg::COUNT_W-1:0] point_count_q;
  logic                        second_nearest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q     <= cnd_pkg::GRID_WIDTH_RESET;
      grid_height_q    <= cnd_pkg::GRID_HEIGHT_RESET;
      point_count_q    <= cnd_pkg::POINT_COUNT_RESET;
      second_nearest_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cnd_pkg::CFG_GRID_WIDTH:     grid_width_q     <= cfg_wdata_i[cnd_pkg::GRID_W-1:0];
        cnd_pkg::CFG_GRID_HEIGHT:    grid_height_q    <= cfg_wdata_i[cnd_pkg::GRID_W-1:0];
        cnd_pkg::CFG_POINT_COUNT:    point_count_q    <= cfg_wdata_i[cnd_pkg::COUNT_W-1:0];
        cnd_pkg::CFG_SECOND_NEAREST: second_nearest_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Effective sides, count and starting distance
  logic [cnd_pkg::SIDE_W-1:0] w_eff;
  logic [cnd_pkg::SIDE_W-1:0] h_eff;
  logic [cnd_pkg::CNT_W-1:0]  n_eff;
  logic [cnd_pkg::AREA_W-1:0] area;

  assign w_eff = side_of(grid_width_q);
  assign h_eff = side_of(grid_height_q);
  assign n_eff = (int'(point_count_q) > cnd_pkg::MAX_POINTS) ?
                 cnd_pkg::CNT_W'(cnd_pkg::MAX_POINTS) : cnd_pkg::CNT_W'(point_count_q);
  assign area  = cnd_pkg::AREA_W'(w_eff) * cnd_pkg::AREA_W'(h_eff);

  // Point table
  logic                        ram_we;
  logic [cnd_pkg::PT_W-1:0]    ram_rdata;
  logic [cnd_pkg::ADDR_W-1:0]  cnt_q;

  assign ram_we = cmd_i.write_pt && (int'(point_slot_i) < cnd_pkg::MAX_POINTS);

  cnd_ram #(
    .Width (cnd_pkg::PT_W),
    .Depth (cnd_pkg::MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnd_pkg::ADDR_W'(point_slot_i)),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (cmd_i.issue),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // Scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + cnd_pkg::ADDR_W'(1);
    end
  end

  // Stage valids
  logic v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Query pixel, held for the scan
  logic [cnd_pkg::COORD_W-1:0] qx_q, qy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
    end
  end

  // Stage 2: wrapped differences
  logic [cnd_pkg::COORD_W-1:0] dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      dx_q <= wrap_diff(ram_rdata[cnd_pkg::PT_W-1:cnd_pkg::COORD_W], qx_q, w_eff);
      dy_q <= wrap_diff(ram_rdata[cnd_pkg::COORD_W-1:0], qy_q, h_eff);
    end
  end

  // Stage 3: squares
  logic [cnd_pkg::SQ_W-1:0] sq_x_q, sq_y_q;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      sq_x_q <= cnd_pkg::SQ_W'(dx_q) * cnd_pkg::SQ_W'(dx_q);
      sq_y_q <= cnd_pkg::SQ_W'(dy_q) * cnd_pkg::SQ_W'(dy_q);
    end
  end

  // Stage 4: sum and running nearest / second-nearest
  logic [cnd_pkg::DIST_W-1:0] pt_dist;
  logic [cnd_pkg::DIST_W-1:0] best_q, second_q;

  assign pt_dist = cnd_pkg::DIST_W'(sq_x_q) + cnd_pkg::DIST_W'(sq_y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      best_q   <= cnd_pkg::DIST_W'(area);
      second_q <= cnd_pkg::DIST_W'(area);
    end else if (v3_q) begin
      if (pt_dist < best_q) begin
        second_q <= best_q;
        best_q   <= pt_dist;
      end else if (pt_dist < second_q) begin
        second_q <= pt_dist;
      end
    end
  end

  // Output register
  logic                       out_valid_q;
  logic [cnd_pkg::DIST_W-1:0] out_dist_q;
  logic [cnd_pkg::DIST_W-1:0] sel_dist;

  assign sel_dist = second_nearest_q ? second_q : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_dist_q <= sel_dist;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_sq_o = out_dist_q;

  // Status
  assign stat_o.cnt_zero   = (n_eff == '0);
  assign stat_o.issue_last = cmd_i.issue &&
                             (cnd_pkg::CNT_W'(cnt_q) == (n_eff - cnd_pkg::CNT_W'(1)));
  assign stat_o.pipe_empty = !(v1_q || v2_q || v3_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Checks
  `CND_ASSERT_NXT(a_min_order, clk_i, rst_ni, v3_q, best_q <= second_q, "minima out of order")
  `CND_ASSERT_IMP(a_load_drained, clk_i, rst_ni, cmd_i.load_out, stat_o.pipe_empty, "early result")
  `CND_ASSERT_IMP(a_within_area, clk_i, rst_ni, cmd_i.load_out, {1'b0, sel_dist} <= area, "past area")

endmodule

// ===== rtl/cellular_nearest_distance_unit.sv =====
// Load beat: written to the point table at acceptance, no result.
// Query beat: scans table slots 0 .. n-1 (none when n is 0), n = point_count
// clamped to 64; the table read port delivers one point per cycle into a four-stage pipe.
// A new beat is taken only in idle, so no query is accepted until the last result is loaded;
// loads are taken while a finished result waits at the output.
// Reset (rst_ni low, asynchronous): grid 512 x 512, point_count 0, nearest; table kept.
module cellular_nearest_distance_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cnd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [cnd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [cnd_pkg::SLOT_W-1:0]      point_slot_i,
  input  logic [cnd_pkg::COORD_W-1:0]     coord_x_i,
  input  logic [cnd_pkg::COORD_W-1:0]     coord_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cnd_pkg::DIST_W-1:0]      distance_sq_o
);

  cnd_pkg::cnd_cmd_t  cmd;
  cnd_pkg::cnd_stat_t stat;

  // Sequencer
  cnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, distance pipe and output register
  cnd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_slot_i  (point_slot_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .distance_sq_o (distance_sq_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

// ===== verif/tb_cellular_nearest_distance_unit.sv =====
module tb_cellular_nearest_distance_unit;

  localparam int          ITEM_TARGET   = 850;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_CYCLES  = 80;
  localparam int          LIMIT_TIME    = 2_000_000;
  localparam int          MAX_IDLE      = 18;
  localparam longint      DIST_MAX      = (64'd1 << cnd_pkg::DIST_W) - 1;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [cnd_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [cnd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            mode_i;
  logic [cnd_pkg::SLOT_W-1:0]      point_slot_i;
  logic [cnd_pkg::COORD_W-1:0]     coord_x_i;
  logic [cnd_pkg::COORD_W-1:0]     coord_y_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [cnd_pkg::DIST_W-1:0]      distance_sq_o;

  // Mirror of the block's point table and registers
  logic [cnd_pkg::COORD_W-1:0]     pt_x_mem [cnd_pkg::MAX_POINTS];
  logic [cnd_pkg::COORD_W-1:0]     pt_y_mem [cnd_pkg::MAX_POINTS];
  logic [cnd_pkg::GRID_W-1:0]      grid_w_cfg;
  logic [cnd_pkg::GRID_W-1:0]      grid_h_cfg;
  logic [cnd_pkg::COUNT_W-1:0]     point_count_cfg;
  logic                            second_sel_cfg;

  logic [cnd_pkg::DIST_W-1:0]      distance_sq_q [$];
  logic [cnd_pkg::DIST_W-1:0]      expected_dist;
  int unsigned                     beats_sent;
  int unsigned                     fail_count;
  bit                              idle_on;

  cellular_nearest_distance_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .point_slot_i  (point_slot_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .distance_sq_o (distance_sq_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Zero side acts as 1, oversized side is clamped
  function automatic longint eff_side(logic [cnd_pkg::GRID_W-1:0] v);
    if (v == 0) return 1;
    if (v > cnd_pkg::MAX_SIDE_PIXELS) return cnd_pkg::MAX_SIDE_PIXELS;
    return longint'(v);
  endfunction

  // Absolute difference folded round the torus; may go negative off-grid
  function automatic longint wrap_delta(longint a, longint b, longint side);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    if (d > side / 2) d = side - d;
    return d;
  endfunction

  // Scan the points in use and pick nearest or runner-up squared distance
  function automatic logic [cnd_pkg::DIST_W-1:0] nearest_distance_sq(
    logic [cnd_pkg::COORD_W-1:0] qx, logic [cnd_pkg::COORD_W-1:0] qy);
    longint w, h, best, runner, dx, dy, d;
    int     n, k;
    w      = eff_side(grid_w_cfg);
    h      = eff_side(grid_h_cfg);
    n      = (point_count_cfg > cnd_pkg::MAX_POINTS) ? cnd_pkg::MAX_POINTS :
             int'(point_count_cfg);
    best   = w * h;
    runner = w * h;
    for (k = 0; k < n; k++) begin
      dx = wrap_delta(longint'(pt_x_mem[k]), longint'(qx), w);
      dy = wrap_delta(longint'(pt_y_mem[k]), longint'(qy), h);
      d  = dx * dx + dy * dy;
      if (d < best) begin
        runner = best;
        best   = d;
      end else if (d < runner) begin
        runner = d;
      end
    end
    d = second_sel_cfg ? runner : best;
    if (d > DIST_MAX) d = DIST_MAX;
    return d[cnd_pkg::DIST_W-1:0];
  endfunction

  // Mostly on-grid coordinates, some anywhere in the field range
  function automatic logic [cnd_pkg::COORD_W-1:0] pick_coord(
    logic [cnd_pkg::GRID_W-1:0] side_cfg);
    longint s;
    s = eff_side(side_cfg);
    if ($urandom_range(0, 4) == 0) return cnd_pkg::COORD_W'($urandom_range(0, 2047));
    return cnd_pkg::COORD_W'($urandom_range(0, int'(s) - 1));
  endfunction

  function automatic logic [cnd_pkg::GRID_W-1:0] pick_side();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return cnd_pkg::GRID_W'(cnd_pkg::MAX_SIDE_PIXELS);
      3: return cnd_pkg::GRID_W'(1);
      4: return cnd_pkg::GRID_W'($urandom_range(cnd_pkg::MAX_SIDE_PIXELS + 1, 4095));
      5, 6: return cnd_pkg::GRID_W'($urandom_range(2, 64));
      default: return cnd_pkg::GRID_W'($urandom_range(1, cnd_pkg::MAX_SIDE_PIXELS));
    endcase
  endfunction

  // Write one register; leave the enable low again before the next write
  task automatic cfg_write(input cnd_pkg::cnd_cfg_e idx,
                           input logic [cnd_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cnd_pkg::CFG_GRID_WIDTH:     grid_w_cfg      = val[cnd_pkg::GRID_W-1:0];
      cnd_pkg::CFG_GRID_HEIGHT:    grid_h_cfg      = val[cnd_pkg::GRID_W-1:0];
      cnd_pkg::CFG_POINT_COUNT:    point_count_cfg = val[cnd_pkg::COUNT_W-1:0];
      cnd_pkg::CFG_SECOND_NEAREST: second_sel_cfg  = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Send one beat; predict its outcome at acceptance
  task automatic send_beat(input cnd_pkg::cnd_mode_e mode,
                           input logic [cnd_pkg::SLOT_W-1:0] slot,
                           input logic [cnd_pkg::COORD_W-1:0] x,
                           input logic [cnd_pkg::COORD_W-1:0] y);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    point_slot_i <= slot;
    coord_x_i    <= x;
    coord_y_i    <= y;
    do @(posedge clk_i); while (!in_ready_o);
    if (mode == cnd_pkg::MODE_LOAD) begin
      pt_x_mem[slot] = x;
      pt_y_mem[slot] = y;
    end else begin
      distance_sq_q.push_back(nearest_distance_sq(x, y));
    end
    beats_sent++;
  endtask

  // Drop valid, wait for every pending distance, then let a trailing load finish
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (distance_sq_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Reset values: 512 x 512 grid, no points scanned
  task automatic test_reset_state();
    send_beat(cnd_pkg::MODE_QUERY, '1, '0, '0);
    send_beat(cnd_pkg::MODE_QUERY, '0, '1, '1);
  endtask

  // Fill every slot so that any point count reads written entries only
  task automatic test_table_fill();
    int k;
    send_beat(cnd_pkg::MODE_LOAD, '0, '0, '0);
    for (k = 1; k < cnd_pkg::MAX_POINTS - 1; k++)
      send_beat(cnd_pkg::MODE_LOAD, cnd_pkg::SLOT_W'(k),
                cnd_pkg::COORD_W'($urandom_range(0, 511)),
                cnd_pkg::COORD_W'($urandom_range(0, 511)));
    send_beat(cnd_pkg::MODE_LOAD, '1, '1, '1);
  endtask

  // Small grid: wrap across the edge, and a tie with the nearest
  task automatic test_wrap_and_ties();
    settle_idle();
    cfg_write(cnd_pkg::CFG_GRID_WIDTH, 16);
    cfg_write(cnd_pkg::CFG_GRID_HEIGHT, 16);
    cfg_write(cnd_pkg::CFG_POINT_COUNT, 3);
    cfg_write(cnd_pkg::CFG_SECOND_NEAREST, 0);
    send_beat(cnd_pkg::MODE_LOAD, 0, 1, 1);
    send_beat(cnd_pkg::MODE_LOAD, 1, 15, 1);
    send_beat(cnd_pkg::MODE_LOAD, 2, 8, 8);
    send_beat(cnd_pkg::MODE_QUERY, 0, 0, 1);
    send_beat(cnd_pkg::MODE_QUERY, 0, 12, 9);
    settle_idle();
    cfg_write(cnd_pkg::CFG_SECOND_NEAREST, 1);
    send_beat(cnd_pkg::MODE_QUERY, 0, 0, 1);
    send_beat(cnd_pkg::MODE_QUERY, 0, 0, 0);
  endtask

  // Zero and oversized sides, oversized count, points off the grid
  task automatic test_side_extremes();
    settle_idle();
    cfg_write(cnd_pkg::CFG_GRID_WIDTH, 0);
    cfg_write(cnd_pkg::CFG_GRID_HEIGHT, 0);
    cfg_write(cnd_pkg::CFG_POINT_COUNT, 127);
    cfg_write(cnd_pkg::CFG_SECOND_NEAREST, 0);
    send_beat(cnd_pkg::MODE_QUERY, 0, 2047, 0);
    send_beat(cnd_pkg::MODE_QUERY, 0, 0, 2047);
    settle_idle();
    cfg_write(cnd_pkg::CFG_GRID_WIDTH, 4095);
    cfg_write(cnd_pkg::CFG_GRID_HEIGHT, 4095);
    cfg_write(cnd_pkg::CFG_POINT_COUNT, cnd_pkg::CFG_DATA_W'(cnd_pkg::MAX_POINTS));
    cfg_write(cnd_pkg::CFG_SECOND_NEAREST, 1);
    send_beat(cnd_pkg::MODE_QUERY, 0, 0, 0);
    send_beat(cnd_pkg::MODE_QUERY, 0, 1024, 2047);
  endtask

  // Random settings per phase, mixed loads and queries, idling on most phases
  task automatic test_random_traffic();
    logic [cnd_pkg::COUNT_W-1:0] count;
    int                          burst;
    while (beats_sent < ITEM_TARGET) begin
      settle_idle();
      case ($urandom_range(0, 5))
        0: count = '0;
        1: count = cnd_pkg::COUNT_W'(cnd_pkg::MAX_POINTS);
        2: count = '1;
        default: count = cnd_pkg::COUNT_W'($urandom_range(1, cnd_pkg::MAX_POINTS));
      endcase
      cfg_write(cnd_pkg::CFG_GRID_WIDTH, pick_side());
      cfg_write(cnd_pkg::CFG_GRID_HEIGHT, pick_side());
      cfg_write(cnd_pkg::CFG_POINT_COUNT, cnd_pkg::CFG_DATA_W'(count));
      cfg_write(cnd_pkg::CFG_SECOND_NEAREST, cnd_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      burst   = $urandom_range(10, 50);
      repeat (burst) begin
        if ($urandom_range(0, 99) < 35)
          send_beat(cnd_pkg::MODE_LOAD,
                    cnd_pkg::SLOT_W'($urandom_range(0, cnd_pkg::MAX_POINTS - 1)),
                    pick_coord(grid_w_cfg), pick_coord(grid_h_cfg));
        else
          send_beat(cnd_pkg::MODE_QUERY,
                    cnd_pkg::SLOT_W'($urandom_range(0, cnd_pkg::MAX_POINTS - 1)),
                    pick_coord(grid_w_cfg), pick_coord(grid_h_cfg));
      end
    end
  endtask

  // Result side: random stall before each beat, or none
  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (distance_sq_q.size() == 0) begin
        $error("distance_sq: expected nothing, actual %0d", distance_sq_o);
        fail_count++;
      end else begin
        expected_dist = distance_sq_q.pop_front();
        if (distance_sq_o !== expected_dist) begin
          $error("distance_sq: expected %0d, actual %0d", expected_dist, distance_sq_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    mode_i          = cnd_pkg::MODE_LOAD;
    point_slot_i    = '0;
    coord_x_i       = '0;
    coord_y_i       = '0;
    grid_w_cfg      = cnd_pkg::GRID_WIDTH_RESET;
    grid_h_cfg      = cnd_pkg::GRID_HEIGHT_RESET;
    point_count_cfg = cnd_pkg::POINT_COUNT_RESET;
    second_sel_cfg  = 1'b0;
    beats_sent      = 0;
    fail_count      = 0;
    idle_on         = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_table_fill();
    test_wrap_and_ties();
    test_side_extremes();
    test_random_traffic();

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
